@@ sv/sstf_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the shortest-seek-time-first scheduler.
// No dependencies; used by sstf_req_mem and sstf_disk_scheduler_unit.

package sstf_pkg;

	localparam int MaxReq  = 64;
	localparam int CylW    = 16;
	localparam int IdxW    = $clog2(MaxReq);
	localparam int CntW    = $clog2(MaxReq + 1);
	localparam int SumW    = 23;
	localparam int TotW    = 22;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_PICK,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic            we;
		logic [IdxW-1:0] waddr;
		logic [CylW-1:0] wdata;
		logic [IdxW-1:0] raddr;
	} mem_req_t;

endpackage

@@ sv/sstf_req_mem.sv @@
`timescale 1ns / 1ps
// Request store: one write port, one read port with registered read data.
// Depends on sstf_pkg for depth, widths and the port struct.

module sstf_req_mem (
	input  logic                     clk,
	input  sstf_pkg::mem_req_t       req,
	output logic [sstf_pkg::CylW-1:0] rd_data_q
);

	logic [sstf_pkg::CylW-1:0] mem [sstf_pkg::MaxReq];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rd_data_q <= mem[req.raddr];
	end

endmodule

@@ sv/sstf_disk_scheduler_unit.sv @@
`timescale 1ns / 1ps
// Top level of the shortest-seek-time-first disk scheduler.
// Depends on sstf_pkg and sstf_req_mem.
//
// Usage:
//   Requests enter on the input channel (in_valid / in_stall), one cylinder
//   per request, and are stored in arrival order, up to 64. A request beyond
//   that is discarded and the batch is flagged as dropped. A request with
//   is_last set closes the batch and starts serving it.
//   Serving emits one result per stored request on the output channel
//   (out_valid / out_stall): cylinder, seek distance, running total, the
//   dropped flag and last_of_run on the final one.
//   Each pick sweeps every stored entry through one distance comparator,
//   one memory read per cycle, and then passes through the drain and pick
//   states before its result is offered on the output channel.
//   A plain request is taken without a stall while idle. in_stall is high
//   while a batch is being served.
//   A stalled result holds its payload; the sweep for the next pick begins
//   only once the current result is taken.
//   start_cylinder is written through cfg_wr_en and is sampled when a batch
//   starts. Reset clears the batch and sets start_cylinder to zero; no
//   clearing pass is needed.

module sstf_disk_scheduler_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [15:0]               start_cylinder,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [15:0]               request_cylinder,
	input  logic                      is_last,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [15:0]               served_cylinder,
	output logic [15:0]               seek_distance,
	output logic [21:0]               total_movement,
	output logic                      dropped,
	output logic                      last_of_run
);

	localparam int CylW = sstf_pkg::CylW;
	localparam int IdxW = sstf_pkg::IdxW;
	localparam int CntW = sstf_pkg::CntW;
	localparam int SumW = sstf_pkg::SumW;
	localparam int TotW = sstf_pkg::TotW;
	localparam logic [CntW-1:0] MaxCnt = CntW'(sstf_pkg::MaxReq);

	sstf_pkg::state_t state_q, state_d;
	sstf_pkg::mem_req_t mem_req;

	logic [CylW-1:0] start_q;
	logic [sstf_pkg::MaxReq-1:0] pending_q;
	logic [CntW-1:0] count_q;
	logic [CntW-1:0] left_q;
	logic [CntW-1:0] scan_q;
	logic [CylW-1:0] head_q;
	logic [SumW-1:0] sum_q;
	logic            ovf_q;

	logic            cmp_vld_s1;
	logic [IdxW-1:0] cmp_idx_s1;
	logic [CylW-1:0] rd_data_s1;

	logic            found_q;
	logic [CylW-1:0] best_d_q;
	logic [CylW-1:0] best_cyl_q;
	logic [IdxW-1:0] best_idx_q;

	logic            out_vld_q;
	logic [CylW-1:0] out_cyl_q;
	logic [CylW-1:0] out_dist_q;
	logic [TotW-1:0] out_tot_q;
	logic            out_drop_q;
	logic            out_last_q;

	logic            in_acc;
	logic            out_acc;
	logic            full;
	logic            scan_end;
	logic            issue;
	logic            cand;
	logic [CylW-1:0] cur_d;
	logic            better;
	logic [SumW-1:0] sum_next;

	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_vld_q && !out_stall;
	assign full     = (count_q == MaxCnt);
	assign scan_end = (scan_q == count_q - CntW'(1));

	assign cur_d  = (rd_data_s1 > head_q) ? (rd_data_s1 - head_q) : (head_q - rd_data_s1);
	assign cand   = cmp_vld_s1 && pending_q[cmp_idx_s1];
	assign better = cand && (!found_q || (cur_d < best_d_q));
	assign sum_next = sum_q + SumW'(best_d_q);

	sstf_req_mem u_mem (
		.clk       (clk),
		.req       (mem_req),
		.rd_data_q (rd_data_s1)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			sstf_pkg::ST_IDLE: begin
				if (in_acc && is_last) begin
					state_d = sstf_pkg::ST_SCAN;
				end
			end
			sstf_pkg::ST_SCAN: begin
				if (scan_end) begin
					state_d = sstf_pkg::ST_DRAIN;
				end
			end
			sstf_pkg::ST_DRAIN: state_d = sstf_pkg::ST_PICK;
			sstf_pkg::ST_PICK:  state_d = sstf_pkg::ST_EMIT;
			sstf_pkg::ST_EMIT: begin
				if (out_acc) begin
					state_d = (left_q == '0) ? sstf_pkg::ST_IDLE : sstf_pkg::ST_SCAN;
				end
			end
			default: state_d = sstf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall      = (state_q != sstf_pkg::ST_IDLE);
		issue         = (state_q == sstf_pkg::ST_SCAN);
		mem_req.we    = (state_q == sstf_pkg::ST_IDLE) && in_acc && !full;
		mem_req.waddr = count_q[IdxW-1:0];
		mem_req.wdata = request_cylinder;
		mem_req.raddr = scan_q[IdxW-1:0];
	end

	assign out_valid       = out_vld_q;
	assign served_cylinder = out_cyl_q;
	assign seek_distance   = out_dist_q;
	assign total_movement  = out_tot_q;
	assign dropped         = out_drop_q;
	assign last_of_run     = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= sstf_pkg::ST_IDLE;
			start_q    <= '0;
			pending_q  <= '0;
			count_q    <= '0;
			left_q     <= '0;
			scan_q     <= '0;
			head_q     <= '0;
			sum_q      <= '0;
			ovf_q      <= 1'b0;
			cmp_vld_s1 <= 1'b0;
			found_q    <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			cmp_vld_s1 <= issue;
			if (cfg_wr_en) begin
				start_q <= start_cylinder;
			end
			if (issue) begin
				scan_q <= scan_q + CntW'(1);
			end
			if (better) begin
				found_q <= 1'b1;
			end
			case (state_q)
				sstf_pkg::ST_IDLE: begin
					if (in_acc) begin
						if (!full) begin
							pending_q[count_q[IdxW-1:0]] <= 1'b1;
							count_q <= count_q + CntW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (is_last) begin
							head_q  <= start_q;
							sum_q   <= '0;
							left_q  <= full ? count_q : count_q + CntW'(1);
							scan_q  <= '0;
							found_q <= 1'b0;
						end
					end
				end
				sstf_pkg::ST_PICK: begin
					pending_q[best_idx_q] <= 1'b0;
					head_q    <= best_cyl_q;
					sum_q     <= sum_next;
					left_q    <= left_q - CntW'(1);
					out_vld_q <= 1'b1;
				end
				sstf_pkg::ST_EMIT: begin
					if (out_acc) begin
						out_vld_q <= 1'b0;
						scan_q    <= '0;
						found_q   <= 1'b0;
						if (left_q == '0) begin
							count_q <= '0;
							sum_q   <= '0;
							ovf_q   <= 1'b0;
							head_q  <= start_q;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= scan_q[IdxW-1:0];
		if (better) begin
			best_d_q   <= cur_d;
			best_cyl_q <= rd_data_s1;
			best_idx_q <= cmp_idx_s1;
		end
		if (state_q == sstf_pkg::ST_PICK) begin
			out_cyl_q  <= best_cyl_q;
			out_dist_q <= best_d_q;
			out_tot_q  <= sum_next[TotW-1:0];
			out_drop_q <= ovf_q;
			out_last_q <= (left_q == CntW'(1));
		end
	end

endmodule
